// ===== hdl/tiny_8bit_cpu_step_assert.svh =====
// Assertion macros used by the checker file.
`ifndef TINY_8BIT_CPU_STEP_ASSERT_SVH
`define TINY_8BIT_CPU_STEP_ASSERT_SVH

// Same-cycle implication.
`define T8C_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("t8c check failed");

// Next-cycle implication.
`define T8C_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("t8c check failed");

`endif

// ===== hdl/t8c_pkg.sv =====
package t8c_pkg;

  // condition field, bits 7:6
  typedef enum logic [1:0] {
    COND_ALWAYS = 2'd0,
    COND_Z      = 2'd1,
    COND_O      = 2'd2,
    COND_E      = 2'd3
  } cond_e;

  // class field, bits 5:4
  typedef enum logic [1:0] {
    CLS_MISC  = 2'd0,
    CLS_ALU   = 2'd1,
    CLS_LDLO  = 2'd2,
    CLS_LDHI  = 2'd3
  } cls_e;

  // misc class operations
  typedef enum logic [3:0] {
    OP_MOV_RA  = 4'h0,
    OP_MOV_AR  = 4'h1,
    OP_MOV_RI  = 4'h2,
    OP_JMP_R   = 4'h3,
    OP_MOV_RX  = 4'h4,
    OP_MOV_XR  = 4'h5,
    OP_MOV_RY  = 4'h6,
    OP_MOV_YR  = 4'h7,
    OP_LOAD    = 4'h8,
    OP_STORE   = 4'h9,
    OP_PIN     = 4'hA,
    OP_POUT    = 4'hB,
    OP_CLR_ALL = 4'hC,
    OP_SET_E   = 4'hD,
    OP_CLR_E   = 4'hE,
    OP_CLR_ZO  = 4'hF
  } misc_op_e;

  // ALU operations
  typedef enum logic [3:0] {
    ALU_ADD   = 4'h0,
    ALU_ADDI  = 4'h1,
    ALU_SUBN  = 4'h2,
    ALU_SUB   = 4'h3,
    ALU_NOTX  = 4'h4,
    ALU_PASSX = 4'h5,
    ALU_AND   = 4'h6,
    ALU_NAND  = 4'h7,
    ALU_OR    = 4'h8,
    ALU_NOR   = 4'h9,
    ALU_XOR   = 4'hA,
    ALU_XNOR  = 4'hB,
    ALU_SHR   = 4'hC,
    ALU_SHR1  = 4'hD,
    ALU_SHL   = 4'hE,
    ALU_SHL1  = 4'hF
  } alu_op_e;

  localparam logic [7:0] PC_LAST = 8'hFF;
  localparam logic [7:0] ALL_ONES = 8'hFF;

  // memory request from the sequencer
  typedef struct packed {
    logic       re;
    logic [7:0] raddr;
    logic       we;
    logic [7:0] waddr;
    logic [7:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic [7:0] res;
    logic       z;
    logic       o;
  } alu_res_t;

  function automatic alu_res_t alu_f(input logic [3:0] op, input logic [7:0] x,
                                     input logic [7:0] y);
    alu_res_t   r;
    logic [8:0] sum;
    logic       carry;
    logic       use_carry;
    sum       = '0;
    carry     = 1'b0;
    use_carry = 1'b0;
    r.res     = '0;
    case (alu_op_e'(op))
      ALU_ADD:   begin sum = {1'b0, x} + {1'b0, y};          use_carry = 1'b1; end
      ALU_ADDI:  begin sum = {1'b0, x} + {1'b0, y} + 9'd1;   use_carry = 1'b1; end
      ALU_SUBN:  begin sum = {1'b0, x} + {1'b0, ~y};         use_carry = 1'b1; end
      ALU_SUB:   begin sum = {1'b0, x} + {1'b0, ~y} + 9'd1;  use_carry = 1'b1; end
      ALU_NOTX:  sum = {1'b0, ~x};
      ALU_PASSX: sum = {1'b0, x};
      ALU_AND:   sum = {1'b0, x & y};
      ALU_NAND:  sum = {1'b0, ~(x & y)};
      ALU_OR:    sum = {1'b0, x | y};
      ALU_NOR:   sum = {1'b0, ~(x | y)};
      ALU_XOR:   sum = {1'b0, x ^ y};
      ALU_XNOR:  sum = {1'b0, ~(x ^ y)};
      ALU_SHR:   sum = {2'b00, x[7:1]};
      ALU_SHR1:  begin sum = {2'b01, x[7:1]}; use_carry = 1'b1; carry = x[0]; end
      ALU_SHL:   sum = {1'b0, x[6:0], 1'b0};
      ALU_SHL1:  begin sum = {1'b0, x[6:0], 1'b1}; use_carry = 1'b1; carry = x[7]; end
      default:   sum = '0;
    endcase
    if (use_carry && !op[3] && !op[2]) carry = sum[8];
    r.res = sum[7:0];
    r.z   = (sum[7:0] == 8'h00);
    r.o   = use_carry ? carry : (sum[7:0] == ALL_ONES);
    return r;
  endfunction

endpackage

// ===== hdl/t8c_mem.sv =====
module t8c_mem
  import t8c_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  mem_req_t   req_i,
  output logic [7:0] rdata_o
);

  logic [7:0]   mem_q [256];
  logic [255:0] valid_q;
  logic [7:0]   rd_q;
  logic         rd_valid_q;
  logic         byp_q;
  logic [7:0]   byp_data_q;

  // never-written bytes read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.we) begin
      valid_q[req_i.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // registered read, write-first on address match
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_q       <= mem_q[req_i.raddr];
      rd_valid_q <= valid_q[req_i.raddr];
      byp_q      <= req_i.we && (req_i.waddr == req_i.raddr);
      byp_data_q <= req_i.wdata;
    end
  end

  assign rdata_o = byp_q ? byp_data_q : (rd_valid_q ? rd_q : 8'h00);

endmodule

// ===== hdl/t8c_core.sv =====
module t8c_core
  import t8c_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       func_i,
  input  logic [7:0] load_address_i,
  input  logic [7:0] load_data_i,
  input  logic [7:0] port_in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       executed_o,
  output logic       halted_now_o,
  output logic       port_read_o,
  output logic       port_write_o,
  output logic [7:0] port_address_o,
  output logic [7:0] port_data_o,
  output logic [7:0] pc_value_o,
  output logic [7:0] r_value_o,
  output logic       zero_flag_o,
  output logic       over_flag_o,
  output logic       error_flag_o,
  output mem_req_t   mem_req_o,
  input  logic [7:0] mem_rdata_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEC  = 2'd1;
  localparam logic [1:0] S_LD   = 2'd2;
  localparam logic [1:0] S_WR   = 2'd3;

  logic [1:0] state_q, state_d;
  logic [7:0] r_q, r_d, pc_q, pc_d, a_q, a_d, x_q, x_d, y_q, y_d;
  logic       z_q, z_d, o_q, o_d, e_q, e_d, halt_q, halt_d;
  logic [7:0] ld_addr_q, ld_data_q, pin_q;

  logic       out_valid_q;
  logic       exec_q, prd_q, pwr_q;
  logic [7:0] paddr_q, pdata_q;

  logic       accept, out_free, need_ld, done, complete, run, inc, do_store;
  logic       exec_d, prd_d, pwr_d;
  logic [7:0] paddr_d, pdata_d;
  logic [7:0] inst;
  cond_e      cond;
  cls_e       cls;
  logic [3:0] low;
  alu_res_t   alu;

  assign inst = mem_rdata_i;
  assign cond = cond_e'(inst[7:6]);
  assign cls  = cls_e'(inst[5:4]);
  assign low  = inst[3:0];
  assign alu  = alu_f(low, x_q, y_q);

  always_comb begin
    case (cond)
      COND_ALWAYS: run = 1'b1;
      COND_Z:      run = z_q;
      COND_O:      run = o_q;
      COND_E:      run = e_q;
      default:     run = 1'b0;
    endcase
  end

  assign need_ld  = (state_q == S_DEC) && !halt_q && run && (cls == CLS_MISC)
                    && (misc_op_e'(low) == OP_LOAD);
  assign do_store = (state_q == S_DEC) && !halt_q && run && (cls == CLS_MISC)
                    && (misc_op_e'(low) == OP_STORE);
  assign out_free = !out_valid_q || out_ready_i;
  assign done     = (state_q == S_WR) || (state_q == S_LD)
                    || ((state_q == S_DEC) && !need_ld);
  assign complete = done && out_free;
  assign in_ready_o = (state_q == S_IDLE) || complete;
  assign accept   = in_valid_i && in_ready_o;

  // execute
  always_comb begin
    r_d = r_q; pc_d = pc_q; a_d = a_q; x_d = x_q; y_d = y_q;
    z_d = z_q; o_d = o_q; e_d = e_q; halt_d = halt_q;
    inc = 1'b0;
    exec_d = 1'b0; prd_d = 1'b0; pwr_d = 1'b0;
    paddr_d = 8'h00; pdata_d = 8'h00;
    if (complete && (state_q == S_LD)) begin
      r_d    = mem_rdata_i;
      inc    = 1'b1;
      exec_d = 1'b1;
    end else if (complete && (state_q == S_DEC) && !halt_q) begin
      exec_d = 1'b1;
      inc    = 1'b1;
      if (run) begin
        case (cls)
          CLS_MISC: begin
            case (misc_op_e'(low))
              OP_MOV_RA:  r_d = a_q;
              OP_MOV_AR:  a_d = r_q;
              OP_MOV_RI:  r_d = pc_q;
              OP_JMP_R:   begin pc_d = r_q; inc = 1'b0; end
              OP_MOV_RX:  r_d = x_q;
              OP_MOV_XR:  x_d = r_q;
              OP_MOV_RY:  r_d = y_q;
              OP_MOV_YR:  y_d = r_q;
              OP_PIN:     begin r_d = pin_q; prd_d = 1'b1; paddr_d = a_q; end
              OP_POUT:    begin pwr_d = 1'b1; paddr_d = a_q; pdata_d = r_q; end
              OP_CLR_ALL: begin z_d = 1'b0; o_d = 1'b0; e_d = 1'b0; end
              OP_SET_E:   e_d = 1'b1;
              OP_CLR_E:   e_d = 1'b0;
              OP_CLR_ZO:  begin z_d = 1'b0; o_d = 1'b0; end
              default:    ; // load and store handled by the memory path
            endcase
          end
          CLS_ALU: begin
            r_d = alu.res;
            z_d = alu.z;
            o_d = alu.o;
          end
          CLS_LDLO: r_d = {r_q[7:4], low};
          CLS_LDHI: r_d = {low, r_q[3:0]};
          default:  ;
        endcase
      end
    end
    if (inc) begin
      if (pc_q == PC_LAST) halt_d = 1'b1;
      pc_d = pc_q + 8'd1;
    end
  end

  // fetch at the updated pc so a new word can start in the finishing cycle
  always_comb begin
    mem_req_o.re    = (accept && !func_i) || need_ld;
    mem_req_o.raddr = need_ld ? a_q : pc_d;
    mem_req_o.we    = complete && ((state_q == S_WR) || do_store);
    mem_req_o.waddr = (state_q == S_WR) ? ld_addr_q : a_q;
    mem_req_o.wdata = (state_q == S_WR) ? ld_data_q : r_q;
  end

  always_comb begin
    state_d = state_q;
    if (need_ld) begin
      state_d = S_LD;
    end else if ((state_q == S_IDLE) || complete) begin
      if (accept) state_d = func_i ? S_WR : S_DEC;
      else        state_d = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      r_q         <= '0;
      pc_q        <= '0;
      a_q         <= '0;
      x_q         <= '0;
      y_q         <= '0;
      z_q         <= 1'b0;
      o_q         <= 1'b0;
      e_q         <= 1'b0;
      halt_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      pc_q    <= pc_d;
      a_q     <= a_d;
      x_q     <= x_d;
      y_q     <= y_d;
      z_q     <= z_d;
      o_q     <= o_d;
      e_q     <= e_d;
      halt_q  <= halt_d;
      if (complete)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ld_addr_q <= load_address_i;
      ld_data_q <= load_data_i;
      pin_q     <= port_in_data_i;
    end
    if (complete) begin
      exec_q  <= exec_d;
      prd_q   <= prd_d;
      pwr_q   <= pwr_d;
      paddr_q <= paddr_d;
      pdata_q <= pdata_d;
    end
  end

  // architectural outputs follow the committed registers
  assign out_valid_o    = out_valid_q;
  assign executed_o     = exec_q;
  assign halted_now_o   = halt_q;
  assign port_read_o    = prd_q;
  assign port_write_o   = pwr_q;
  assign port_address_o = paddr_q;
  assign port_data_o    = pdata_q;
  assign pc_value_o     = pc_q;
  assign r_value_o      = r_q;
  assign zero_flag_o    = z_q;
  assign over_flag_o    = o_q;
  assign error_flag_o   = e_q;

endmodule

// ===== hdl/tiny_8bit_cpu_step.sv =====
// Channel  | Handshake              | Word contents
// ---------+------------------------+----------------------------------------------
// in       | in_valid_i/in_ready_o  | func, load_address, load_data, port_in_data
// out      | out_valid_o/out_ready_i| executed, halted_now, port_read/write,
//          |                        | port_address/data, pc, r, z/o/e flags
//
// A step word runs a fetch read, then decode/commit; a memory load adds a
// data read at A before the commit. A write word latches, then writes.
// The memory has a single port per direction and holds 256 bytes.
// A new word is taken in the cycle the previous one commits.
// Reset clears control state, r/a/x/y/pc, flags, valid bits (memory reads as zero).
// A result waiting in the output register stalls only the next commit.
module tiny_8bit_cpu_step
  import t8c_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       func_i,
  input  logic [7:0] load_address_i,
  input  logic [7:0] load_data_i,
  input  logic [7:0] port_in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       executed_o,
  output logic       halted_now_o,
  output logic       port_read_o,
  output logic       port_write_o,
  output logic [7:0] port_address_o,
  output logic [7:0] port_data_o,
  output logic [7:0] pc_value_o,
  output logic [7:0] r_value_o,
  output logic       zero_flag_o,
  output logic       over_flag_o,
  output logic       error_flag_o
);

  mem_req_t   mem_req;
  logic [7:0] mem_rdata;

  // unified program/data memory, one read and one write port
  t8c_mem u_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mem_req),
    .rdata_o(mem_rdata)
  );

  // sequencer, register file, ALU and output register
  t8c_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .load_address_i(load_address_i),
    .load_data_i   (load_data_i),
    .port_in_data_i(port_in_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .executed_o    (executed_o),
    .halted_now_o  (halted_now_o),
    .port_read_o   (port_read_o),
    .port_write_o  (port_write_o),
    .port_address_o(port_address_o),
    .port_data_o   (port_data_o),
    .pc_value_o    (pc_value_o),
    .r_value_o     (r_value_o),
    .zero_flag_o   (zero_flag_o),
    .over_flag_o   (over_flag_o),
    .error_flag_o  (error_flag_o),
    .mem_req_o     (mem_req),
    .mem_rdata_i   (mem_rdata)
  );

endmodule

// ===== hdl/t8c_checker.sv =====
`include "tiny_8bit_cpu_step_assert.svh"

module t8c_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       executed_o,
  input logic       halted_now_o,
  input logic       port_read_o,
  input logic       port_write_o,
  input logic [7:0] port_address_o,
  input logic [7:0] pc_value_o
);

  // a pending result word is not dropped
  `T8C_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)

  // at most one port access per step
  `T8C_ASSERT_IMPL(a_port_excl, clk_i, rst_ni, out_valid_o, !(port_read_o && port_write_o))

  // no port activity unless a step ran
  `T8C_ASSERT_IMPL(a_port_quiet, clk_i, rst_ni, out_valid_o && !executed_o,
                   !port_read_o && !port_write_o && (port_address_o == 8'h00))

  // the step that halts wraps the counter to zero
  `T8C_ASSERT_IMPL(a_halt_wrap, clk_i, rst_ni, out_valid_o && executed_o && halted_now_o,
                   pc_value_o == 8'h00)

endmodule

bind tiny_8bit_cpu_step t8c_checker u_t8c_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .executed_o    (executed_o),
  .halted_now_o  (halted_now_o),
  .port_read_o   (port_read_o),
  .port_write_o  (port_write_o),
  .port_address_o(port_address_o),
  .pc_value_o    (pc_value_o)
);
